// ===== rtl/unm_pkg.sv =====
// Shared types and widths for the triangle unit-normal pipeline.
// No dependencies.
`default_nettype none
package unm_pkg;

  localparam int COORD_W = 16;
  localparam int EDGE_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int MAG_W   = PROD_W - 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int LEN2_W  = SQ_W + 2;
  localparam int ROOT_W  = 16;
  localparam int QFRAC_SH = 30;
  localparam int RES_W   = SQ_W + QFRAC_SH;
  localparam int P_W     = LEN2_W + ROOT_W;
  localparam int ACC_W   = P_W + ROOT_W + 1;
  localparam int STEPS   = ROOT_W;
  localparam int LANES   = 3;
  localparam int OUT_W   = 16;

  // One root lane: partial root, root times squared length, remainder.
  typedef struct packed {
    logic [ROOT_W-1:0] s;
    logic [P_W-1:0]    p;
    logic [RES_W-1:0]  r;
  } lane_t;

endpackage
`default_nettype wire

// ===== rtl/unm_root_stage.sv =====
// One bit of the restoring square-root recurrence for all three lanes.
// Depends on unm_pkg.
`default_nettype none
module unm_root_stage (
  input  wire logic                         clk,
  input  wire logic                         ce,
  input  wire logic [3:0]                   k,
  input  wire logic [unm_pkg::LEN2_W-1:0]   len2,
  input  wire unm_pkg::lane_t               lane_i [unm_pkg::LANES],
  output unm_pkg::lane_t                    lane_o [unm_pkg::LANES]
);
  import unm_pkg::*;

  lane_t lane_r   [LANES];
  lane_t lane_nxt [LANES];

  always_comb begin
    logic [ACC_W-1:0] t;
    logic             fits;
    for (int i = 0; i < LANES; i++) begin
      t = (ACC_W'(lane_i[i].p) << ({1'b0, k} + 5'd1)) + (ACC_W'(len2) << {k, 1'b0});
      fits = (t <= ACC_W'(lane_i[i].r));
      lane_nxt[i] = lane_i[i];
      if (fits) begin
        lane_nxt[i].r = lane_i[i].r - t[RES_W-1:0];
        lane_nxt[i].p = lane_i[i].p + (P_W'(len2) << k);
        lane_nxt[i].s = lane_i[i].s | (ROOT_W'(1) << k);
      end
    end
  end

  // hold on stall
  always_ff @(posedge clk) begin
    if (ce) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule
`default_nettype wire

// ===== rtl/triangle_unit_normal.sv =====
// Top level of the triangle unit-normal pipeline.
// Depends on unm_pkg and unm_root_stage.
`default_nettype none
// Takes one triangle per beat and returns its unit face normal in signed Q1.14
// (16384 = 1.0), rounded to nearest with halves away from zero, plus a
// degenerate flag when the cross product is zero (components then zero).
// Fully pipelined: one beat per cycle when the output is taken, with 6 front
// stages for edges, cross product, squares and length, 16 square-root bit
// stages and 1 output stage. The whole pipe advances together; it holds
// while the output register is full and not taken.
module triangle_unit_normal (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z (16 bits each)
  input  wire logic [143:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // normal_x, normal_y, normal_z (16 bits each)
  output logic [47:0]       out_tdata,
  // degenerate
  output logic [0:0]        out_tuser
);
  import unm_pkg::*;

  logic ce;
  logic out_vld_r;
  assign ce         = !out_vld_r || out_tready;
  assign in_tready  = ce;
  assign out_tvalid = out_vld_r;

  // Unpack vertices.
  logic signed [COORD_W-1:0] vin [9];
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      vin[i] = in_tdata[i*COORD_W +: COORD_W];
    end
  end

  // Stage 1: edges e1 = v1 - v0, e2 = v2 - v0.
  logic              v1_r;
  logic signed [EDGE_W-1:0] ax_r, ay_r, az_r, bx_r, by_r, bz_r;
  always_ff @(posedge clk) begin
    if (ce) begin
      ax_r <= EDGE_W'(vin[3]) - EDGE_W'(vin[0]);
      ay_r <= EDGE_W'(vin[4]) - EDGE_W'(vin[1]);
      az_r <= EDGE_W'(vin[5]) - EDGE_W'(vin[2]);
      bx_r <= EDGE_W'(vin[6]) - EDGE_W'(vin[0]);
      by_r <= EDGE_W'(vin[7]) - EDGE_W'(vin[1]);
      bz_r <= EDGE_W'(vin[8]) - EDGE_W'(vin[2]);
    end
  end

  // Stage 2: six partial products of the cross product.
  logic v2_r;
  logic signed [PROD_W-1:0] p_aybz_r, p_azby_r, p_azbx_r, p_axbz_r, p_axby_r, p_aybx_r;
  always_ff @(posedge clk) begin
    if (ce) begin
      p_aybz_r <= PROD_W'(ay_r) * PROD_W'(bz_r);
      p_azby_r <= PROD_W'(az_r) * PROD_W'(by_r);
      p_azbx_r <= PROD_W'(az_r) * PROD_W'(bx_r);
      p_axbz_r <= PROD_W'(ax_r) * PROD_W'(bz_r);
      p_axby_r <= PROD_W'(ax_r) * PROD_W'(by_r);
      p_aybx_r <= PROD_W'(ay_r) * PROD_W'(bx_r);
    end
  end

  // Stage 3: cross product; y keeps the corrected sign.
  logic v3_r;
  logic signed [PROD_W-1:0] c_r [LANES];
  always_ff @(posedge clk) begin
    if (ce) begin
      c_r[0] <= p_aybz_r - p_azby_r;
      c_r[1] <= p_azbx_r - p_axbz_r;
      c_r[2] <= p_axby_r - p_aybx_r;
    end
  end

  // Stage 4: magnitudes and signs.
  logic v4_r;
  logic [MAG_W-1:0] m_r   [LANES];
  logic [LANES-1:0] sgn4_r;
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < LANES; i++) begin
        m_r[i]    <= c_r[i][PROD_W-1] ? MAG_W'(-c_r[i]) : MAG_W'(c_r[i]);
        sgn4_r[i] <= c_r[i][PROD_W-1];
      end
    end
  end

  // Stage 5: squares.
  logic v5_r;
  logic [SQ_W-1:0]  sq_r  [LANES];
  logic [LANES-1:0] sgn5_r;
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < LANES; i++) begin
        sq_r[i] <= SQ_W'(m_r[i]) * SQ_W'(m_r[i]);
      end
      sgn5_r <= sgn4_r;
    end
  end

  // Stage 6: squared length and root seeds; lanes start at s = 0.
  logic              vld_pipe  [STEPS+1];
  logic [LEN2_W-1:0] len2_pipe [STEPS+1];
  logic [LANES-1:0]  sgn_pipe  [STEPS+1];
  logic              deg_pipe  [STEPS+1];
  lane_t             lane_pipe [STEPS+1][LANES];
  logic [LEN2_W-1:0] len2_sum;

  assign len2_sum = LEN2_W'(sq_r[0]) + LEN2_W'(sq_r[1]) + LEN2_W'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (ce) begin
      len2_pipe[0] <= len2_sum;
      sgn_pipe[0]  <= sgn5_r;
      deg_pipe[0]  <= (len2_sum == '0);
      for (int i = 0; i < LANES; i++) begin
        lane_pipe[0][i].s <= '0;
        lane_pipe[0][i].p <= '0;
        lane_pipe[0][i].r <= RES_W'(sq_r[i]) << QFRAC_SH;
      end
    end
  end

  // Valid bits for the front stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      vld_pipe[0] <= 1'b0;
    end else if (ce) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      vld_pipe[0] <= v5_r;
    end
  end

  // Square-root stages: stage j decides root bit 15 - j.
  for (genvar j = 0; j < STEPS; j++) begin : g_root
    unm_root_stage u_stage (
      .clk    (clk),
      .ce     (ce),
      .k      (4'(STEPS - 1 - j)),
      .len2   (len2_pipe[j]),
      .lane_i (lane_pipe[j]),
      .lane_o (lane_pipe[j+1])
    );

    // carry side information along with the lanes
    always_ff @(posedge clk) begin
      if (ce) begin
        len2_pipe[j+1] <= len2_pipe[j];
        sgn_pipe[j+1]  <= sgn_pipe[j];
        deg_pipe[j+1]  <= deg_pipe[j];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_pipe[j+1] <= 1'b0;
      end else if (ce) begin
        vld_pipe[j+1] <= vld_pipe[j];
      end
    end
  end

  // Output stage: largest odd root gives the rounded component.
  logic [OUT_W-1:0] nrm_r [LANES];
  logic             deg_r;
  logic [OUT_W-1:0] q_mag [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      q_mag[i] = OUT_W'((17'(lane_pipe[STEPS][i].s) + 17'd1) >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      deg_r <= deg_pipe[STEPS];
      for (int i = 0; i < LANES; i++) begin
        if (deg_pipe[STEPS]) begin
          nrm_r[i] <= '0;
        end else if (sgn_pipe[STEPS][i]) begin
          nrm_r[i] <= OUT_W'(0) - q_mag[i];
        end else begin
          nrm_r[i] <= q_mag[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ce) begin
      out_vld_r <= vld_pipe[STEPS];
    end
  end

  assign out_tdata = {nrm_r[2], nrm_r[1], nrm_r[0]};
  assign out_tuser = deg_r;

endmodule
`default_nettype wire

// ===== dv/triangle_unit_normal_checker.sv =====
// Checker for the triangle unit-normal block: watches both streams, predicts each normal.
// Depends on the port layout of triangle_unit_normal only.
module triangle_unit_normal_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [143:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [47:0]  out_tdata,
  input  logic [0:0]   out_tuser,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic        degen;
  } normal_t;

  normal_t expected_normals[$];

  // Largest k in 0..16384 with len2*(2k-1)^2 <= (32768*|c|)^2, sign restored.
  function automatic logic [15:0] unit_part(logic signed [63:0] c, logic [127:0] len2);
    logic [63:0]  mag;
    logic [127:0] rhs;
    logic [127:0] lhs;
    logic [63:0]  lo;
    logic [63:0]  hi;
    logic [63:0]  mid;
    logic [63:0]  odd;
    mag = (c < 0) ? -c : c;
    rhs = ({64'd0, mag} * {64'd0, mag}) << 30;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      odd = 2 * mid - 1;
      lhs = len2 * {64'd0, odd * odd};
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    if (c < 0) lo = -lo;
    return lo[15:0];
  endfunction

  function automatic normal_t face_normal(logic [143:0] d);
    logic signed [63:0] vx0, vy0, vz0, ax, ay, az, bx, by, bz, cx, cy, cz;
    logic [127:0]       mx, my, mz;
    logic [127:0]       len2;
    normal_t            n;
    vx0 = $signed(d[15:0]);
    vy0 = $signed(d[31:16]);
    vz0 = $signed(d[47:32]);
    ax = $signed(d[63:48]) - vx0;
    ay = $signed(d[79:64]) - vy0;
    az = $signed(d[95:80]) - vz0;
    bx = $signed(d[111:96]) - vx0;
    by = $signed(d[127:112]) - vy0;
    bz = $signed(d[143:128]) - vz0;
    cx = ay * bz - az * by;
    cy = -(ax * bz - az * bx);
    cz = ax * by - ay * bx;
    if (cx == 0 && cy == 0 && cz == 0) begin
      n = '0;
      n.degen = 1'b1;
      return n;
    end
    // magnitudes widened first so the squares keep all their bits
    mx = {64'd0, ((cx < 0) ? -cx : cx)};
    my = {64'd0, ((cy < 0) ? -cy : cy)};
    mz = {64'd0, ((cz < 0) ? -cz : cz)};
    len2 = mx * mx + my * my + mz * mz;
    n.nx = unit_part(cx, len2);
    n.ny = unit_part(cy, len2);
    n.nz = unit_part(cz, len2);
    n.degen = 1'b0;
    return n;
  endfunction

  task automatic queue_normal(normal_t n);
    expected_normals = {expected_normals, n};
  endtask

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, $signed(got),
             $signed(want), $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    normal_t want;
    if (rst_n && in_tvalid && in_tready) queue_normal(face_normal(in_tdata));
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_normals.size() == 0) begin
        report("unexpected result beat", out_tdata[15:0], 16'd0);
      end else begin
        want = expected_normals.pop_front();
        if (out_tdata[15:0] !== want.nx) report("normal_x", out_tdata[15:0], want.nx);
        if (out_tdata[31:16] !== want.ny) report("normal_y", out_tdata[31:16], want.ny);
        if (out_tdata[47:32] !== want.nz) report("normal_z", out_tdata[47:32], want.nz);
        if (out_tuser[0] !== want.degen)
          report("degenerate", {15'd0, out_tuser[0]}, {15'd0, want.degen});
      end
    end
    pending = expected_normals.size();
  end

endmodule

// ===== dv/triangle_unit_normal_tb.sv =====
// Testbench top for triangle_unit_normal: drives triangles, stalls the result side.
// Depends on triangle_unit_normal and triangle_unit_normal_checker.
module triangle_unit_normal_tb;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [143:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [47:0]  out_tdata;
  logic [0:0]   out_tuser;
  int           fail_count;
  int           pending;
  int           cycles = 0;

  // Stall controls for the sender and receiver processes.
  bit in_idle_on = 1;
  bit out_idle_on = 1;
  bit out_hold = 0;

  always #10 clk = ~clk;

  triangle_unit_normal DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  triangle_unit_normal_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .fail_count(fail_count), .pending(pending)
  );

  // Timeout: generous against the pipeline latency and ~21% stall on each side.
  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random ready, or held low while out_hold is set.
  always @(negedge clk) begin
    if (!rst_n || out_hold) out_tready <= 1'b0;
    else out_tready <= !(out_idle_on && $urandom_range(99) < 21);
  end

  // Offer one triangle beat; idle gaps fall before it at random.
  task automatic send_triangle(logic [143:0] d);
    while (in_idle_on && $urandom_range(99) < 21) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  function automatic logic [143:0] pack_tri(int x0, int y0, int z0, int x1, int y1,
                                            int z1, int x2, int y2, int z2);
    return {16'(z2), 16'(y2), 16'(x2), 16'(z1), 16'(y1), 16'(x1), 16'(z0), 16'(y0), 16'(x0)};
  endfunction

  function automatic int rnd16();
    return $signed(16'($urandom));
  endfunction

  // Fully random, small or scaled-down triangles, plus collinear and coincident ones.
  function automatic logic [143:0] random_triangle();
    int x0, y0, z0, dx, dy, dz, k;
    case ($urandom_range(5))
      0, 1: return {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
      2: begin
        x0 = $urandom_range(40) - 20; y0 = $urandom_range(40) - 20;
        z0 = $urandom_range(40) - 20;
        return pack_tri(x0, y0, z0, x0 + $urandom_range(6) - 3, y0 + $urandom_range(6) - 3,
                        z0 + $urandom_range(6) - 3, x0 + $urandom_range(6) - 3,
                        y0 + $urandom_range(6) - 3, z0 + $urandom_range(6) - 3);
      end
      3: begin
        // collinear: v2 = v0 + k*(v1 - v0)
        x0 = $urandom_range(2000) - 1000; y0 = $urandom_range(2000) - 1000;
        z0 = $urandom_range(2000) - 1000;
        dx = $urandom_range(200) - 100; dy = $urandom_range(200) - 100;
        dz = $urandom_range(200) - 100; k = $urandom_range(20) - 10;
        return pack_tri(x0, y0, z0, x0 + dx, y0 + dy, z0 + dz,
                        x0 + k * dx, y0 + k * dy, z0 + k * dz);
      end
      4: begin
        x0 = rnd16(); y0 = rnd16(); z0 = rnd16();
        return pack_tri(x0, y0, z0, x0, y0, z0, rnd16(), rnd16(), rnd16());
      end
      default: return pack_tri(rnd16() / 64, rnd16() / 64, rnd16() / 64, rnd16() / 64,
                               rnd16() / 64, rnd16() / 64, rnd16() / 64, rnd16() / 64,
                               rnd16() / 64);
    endcase
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: degenerate, axis normals of both signs, extremes, exact halves area.
    send_triangle('0);
    send_triangle({144{1'b1}});
    send_triangle(pack_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
    send_triangle(pack_tri(0, 0, 0, 0, 1, 0, 1, 0, 0));
    send_triangle(pack_tri(0, 0, 0, 0, 1, 0, 0, 0, 1));
    send_triangle(pack_tri(0, 0, 0, 0, 0, 1, 0, 1, 0));
    send_triangle(pack_tri(0, 0, 0, 0, 0, 1, 1, 0, 0));
    send_triangle(pack_tri(0, 0, 0, 1, 0, 0, 0, 0, 1));
    send_triangle(pack_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                           -32768, 32767, -32768));
    send_triangle(pack_tri(32767, 32767, 32767, -32768, 32767, 32767,
                           32767, -32768, 32767));
    send_triangle(pack_tri(-32768, -32768, -32768, 32767, 32767, -32768,
                           -32768, 32767, 32767));
    send_triangle(pack_tri(32767, -32768, 32767, -32768, 32767, -32768,
                           32767, 32767, -32768));
    send_triangle(pack_tri(1, 2, 3, 2, 4, 6, 3, 6, 9));
    send_triangle(pack_tri(5, 5, 5, 5, 5, 5, 5, 5, 5));
    send_triangle(pack_tri(0, 0, 0, 1, 1, 0, 1, 0, 1));
    send_triangle(pack_tri(0, 0, 0, 3, 0, 0, 0, 4, 1));
    send_triangle(pack_tri(0, 0, 0, 1, 2, 3, 4, 5, 6));
    send_triangle(pack_tri(-32768, 0, 0, 32767, 0, 0, 0, 32767, -32768));

    // Random, with idling on both sides.
    repeat (500) send_triangle(random_triangle());

    // Stretch with no idling anywhere.
    in_idle_on = 0;
    out_idle_on = 0;
    repeat (300) send_triangle(random_triangle());

    // Hold off the receiver so the pipe fills and backs up into the input.
    fork
      begin
        out_hold = 1;
        repeat (200) @(negedge clk);
        out_hold = 0;
      end
      repeat (120) send_triangle(random_triangle());
    join
    in_tvalid <= 1'b0;
    in_idle_on = 1;
    out_idle_on = 1;

    // Pause until the pipe is empty, then go on.
    wait (pending == 0);
    @(negedge clk);
    repeat (530) send_triangle(random_triangle());
    in_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/unm_pkg.sv
rtl/unm_root_stage.sv
rtl/triangle_unit_normal.sv
dv/triangle_unit_normal_checker.sv
dv/triangle_unit_normal_tb.sv
